// ===== rtl/tjss_pkg.sv =====
// Shared types and constants for the tree joint state sampler.
package tjss_pkg;

	// Width of one sort weight: a full product of two Q0.32 values.
	localparam int WEIGHT_W = 64;
	// Width of a state index carried through the sort chain (up to 16 states).
	localparam int IDX_W = 4;

	// Request codes of the input transaction.
	typedef enum logic [1:0] {
		REQ_LOAD_LIK   = 2'd0,
		REQ_LOAD_TRANS = 2'd1,
		REQ_ROOT       = 2'd2,
		REQ_NODE       = 2'd3
	} req_t;

	// Configuration register indexes.
	localparam logic CFG_STATE_COUNT = 1'b0;
	localparam logic CFG_ZERO_BASED  = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PARENT = 7'b0000010,
		ST_FEED   = 7'b0000100,
		ST_FLUSH  = 7'b0001000,
		ST_THRESH = 7'b0010000,
		ST_SCAN   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	// One weighted state travelling through the sort chain.
	typedef struct packed {
		logic                vld;
		logic [IDX_W-1:0]    idx;
		logic [WEIGHT_W-1:0] weight;
	} sort_entry_t;

	// Control shared by every sort cell.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/tjss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tjss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tjss_sort_cell.sv =====
// One cell of the systolic descending sort chain.
module tjss_sort_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tjss_pkg::cell_ctrl_t ctrl,
	input  tjss_pkg::sort_entry_t ins_in,
	input  tjss_pkg::sort_entry_t shift_in,
	output tjss_pkg::sort_entry_t held,
	output tjss_pkg::sort_entry_t pass
);

	tjss_pkg::sort_entry_t held_q;
	tjss_pkg::sort_entry_t pass_q;

	// Keep the larger entry, hand the smaller one to the next cell.
	// Equal weights are ordered by index, so lower indexes stay ahead
	// whatever order the entries reach this cell in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (ctrl.clear) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (ctrl.shift) begin
			held_q <= shift_in;
			pass_q <= '0;
		end else if (ins_in.vld) begin
			if (!held_q.vld || (ins_in.weight > held_q.weight)
				|| ((ins_in.weight == held_q.weight) && (ins_in.idx < held_q.idx))) begin
				held_q <= ins_in;
				pass_q <= held_q;
			end else begin
				pass_q <= ins_in;
			end
		end else begin
			pass_q <= '0;
		end
	end

	assign held = held_q;
	assign pass = pass_q;

endmodule

// ===== rtl/tree_joint_state_sampler.sv =====
// Top level of the tree joint state sampler: sequencer, weight unit and sort chain.
//
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | req_type, row_index, column_index,
//         |           |                     | weight_value, node_slot, parent_slot,
//         |           |                     | uniform_draw
// out     | output    | out_valid/out_stall | sampled_state, sampled_node
// cfg     | input     | cfg_write_en        | cfg_index, cfg_data
//
// A sample steps through a store read, the weight feed of the active states, a chain
// flush, the threshold steps, a scan of the sorted chain head and a finish; a load is
// written as it is accepted. The sort chain and the single transition RAM read port
// set how long a sample takes.
// Reset clears control state only; the stores hold nothing until written.
// A stalled result waits in the output register while the next item is accepted.
module tree_joint_state_sampler #(
	parameter int MAX_STATES = 8,
	parameter int MAX_NODES  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [2:0]  row_index,
	input  logic [2:0]  column_index,
	input  logic [31:0] weight_value,
	input  logic [9:0]  node_slot,
	input  logic [9:0]  parent_slot,
	input  logic [31:0] uniform_draw,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  sampled_state,
	output logic [9:0]  sampled_node,
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int SIW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int KW  = $clog2(MAX_STATES + 1);
	localparam int TD  = MAX_STATES * MAX_STATES;
	localparam int TAW = $clog2(TD);
	localparam int NAW = $clog2(MAX_NODES);
	localparam int FCW = $clog2(MAX_STATES + 3);
	localparam int WW  = tjss_pkg::WEIGHT_W;

	tjss_pkg::state_t state_q;

	logic [3:0]  state_count_q;
	logic        zero_based_q;
	logic [31:0] lik_q [MAX_STATES];

	logic            root_q;
	logic [9:0]      node_q;
	logic            par_oor_q;
	logic [31:0]     u_q;
	logic [SIW-1:0]  j_q;
	logic [SIW-1:0]  feed_cnt_q;
	logic [FCW-1:0]  flush_cnt_q;
	logic [1:0]      thr_cnt_q;
	logic [SIW-1:0]  scan_cnt_q;
	logic [3:0]      chosen_q;

	logic                     fd_s1_vld;
	logic [tjss_pkg::IDX_W-1:0] fd_s1_idx;
	logic [31:0]              fd_s1_lik;
	tjss_pkg::sort_entry_t    wt_s2;

	logic [WW-1:0] total_q;
	logic [WW-1:0] mul_q;
	logic [32:0]   frac_q;
	logic [WW-1:0] thresh_q;
	logic [WW-1:0] cum_q;

	logic [KW-1:0]  k_active;
	logic           in_acc;
	logic           is_sample;
	logic [TAW-1:0] trans_waddr;
	logic [TAW-1:0] trans_raddr;
	logic           trans_we;
	logic [31:0]    trans_rdata;
	logic           store_we;
	logic [NAW-1:0] store_waddr;
	logic [SIW-1:0] store_rdata;
	logic [WW-1:0]  cum_next;
	logic           scan_hit;
	logic           feed_last;
	logic           out_free;
	logic [63:0]    node_prod;

	tjss_pkg::cell_ctrl_t  cell_ctrl;
	tjss_pkg::sort_entry_t cell_held [MAX_STATES];
	tjss_pkg::sort_entry_t cell_pass [MAX_STATES];

	// Active state count, saturated into the supported range.
	always_comb begin
		if (state_count_q < 4'd2) begin
			k_active = KW'(2);
		end else if (32'(state_count_q) > MAX_STATES) begin
			k_active = KW'(MAX_STATES);
		end else begin
			k_active = KW'(state_count_q);
		end
	end

	assign in_stall  = (state_q != tjss_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_sample = (req_type == tjss_pkg::REQ_ROOT) || (req_type == tjss_pkg::REQ_NODE);
	assign feed_last = (KW'(feed_cnt_q) == (k_active - KW'(1)));
	assign out_free  = !out_valid || !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= 4'd2;
			zero_based_q  <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				tjss_pkg::CFG_STATE_COUNT: state_count_q <= cfg_data;
				tjss_pkg::CFG_ZERO_BASED:  zero_based_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Likelihood vector loads.
	always_ff @(posedge clk) begin
		if (in_acc && (req_type == tjss_pkg::REQ_LOAD_LIK) && (32'(row_index) < MAX_STATES)) begin
			lik_q[SIW'(row_index)] <= weight_value;
		end
	end

	// Transition matrix memory: loads write, the weight unit reads down the parent state's column.
	assign trans_we    = in_acc && (req_type == tjss_pkg::REQ_LOAD_TRANS)
		&& (32'(row_index) < MAX_STATES) && (32'(column_index) < MAX_STATES);
	assign trans_waddr = TAW'(32'(row_index) * MAX_STATES + 32'(column_index));
	assign trans_raddr = TAW'(32'(feed_cnt_q) * MAX_STATES + 32'(j_q));

	tjss_ram #(
		.WIDTH (32),
		.DEPTH (TD)
	) u_trans_ram (
		.clk   (clk),
		.we    (trans_we),
		.waddr (trans_waddr),
		.wdata (weight_value),
		.raddr (trans_raddr),
		.rdata (trans_rdata)
	);

	// Node state memory: read for the parent at acceptance, written when done.
	assign store_we    = (state_q == tjss_pkg::ST_DONE) && out_free
		&& (32'(node_q) < MAX_NODES);
	assign store_waddr = NAW'(node_q);

	tjss_ram #(
		.WIDTH (SIW),
		.DEPTH (MAX_NODES)
	) u_store_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (SIW'(chosen_q)),
		.raddr (NAW'(parent_slot)),
		.rdata (store_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tjss_pkg::ST_IDLE;
			feed_cnt_q  <= '0;
			flush_cnt_q <= '0;
			thr_cnt_q   <= '0;
			scan_cnt_q  <= '0;
		end else begin
			case (state_q)
				tjss_pkg::ST_IDLE: begin
					if (in_acc && is_sample) begin
						state_q <= tjss_pkg::ST_PARENT;
					end
				end
				tjss_pkg::ST_PARENT: begin
					feed_cnt_q <= '0;
					state_q    <= tjss_pkg::ST_FEED;
				end
				tjss_pkg::ST_FEED: begin
					if (feed_last) begin
						flush_cnt_q <= '0;
						state_q     <= tjss_pkg::ST_FLUSH;
					end else begin
						feed_cnt_q <= feed_cnt_q + SIW'(1);
					end
				end
				tjss_pkg::ST_FLUSH: begin
					if (32'(flush_cnt_q) == MAX_STATES + 1) begin
						thr_cnt_q <= '0;
						state_q   <= tjss_pkg::ST_THRESH;
					end else begin
						flush_cnt_q <= flush_cnt_q + FCW'(1);
					end
				end
				tjss_pkg::ST_THRESH: begin
					if (thr_cnt_q == 2'd2) begin
						scan_cnt_q <= '0;
						state_q    <= tjss_pkg::ST_SCAN;
					end else begin
						thr_cnt_q <= thr_cnt_q + 2'd1;
					end
				end
				tjss_pkg::ST_SCAN: begin
					if (scan_hit) begin
						state_q <= tjss_pkg::ST_DONE;
					end else begin
						scan_cnt_q <= scan_cnt_q + SIW'(1);
					end
				end
				tjss_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= tjss_pkg::ST_IDLE;
					end
				end
				default: state_q <= tjss_pkg::ST_IDLE;
			endcase
		end
	end

	// Request fields held for the duration of one sample.
	always_ff @(posedge clk) begin
		if (in_acc && is_sample) begin
			root_q    <= (req_type == tjss_pkg::REQ_ROOT);
			node_q    <= (req_type == tjss_pkg::REQ_ROOT) ? 10'd0 : node_slot;
			par_oor_q <= (32'(parent_slot) >= MAX_NODES);
			u_q       <= uniform_draw;
		end
	end

	// Parent state, forced to zero when out of range.
	always_ff @(posedge clk) begin
		if (state_q == tjss_pkg::ST_PARENT) begin
			if (par_oor_q || (32'(store_rdata) >= MAX_STATES)) begin
				j_q <= '0;
			end else begin
				j_q <= store_rdata;
			end
		end
	end

	// Weight unit: likelihood read, then product or root weight.
	assign node_prod = 64'(fd_s1_lik) * 64'(trans_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_s1_vld <= 1'b0;
			wt_s2     <= '0;
		end else begin
			fd_s1_vld <= (state_q == tjss_pkg::ST_FEED);
			wt_s2.vld <= fd_s1_vld;
			wt_s2.idx <= fd_s1_idx;
			wt_s2.weight <= root_q ? WW'(fd_s1_lik) : {3'b000, node_prod[63:3]};
		end
	end

	always_ff @(posedge clk) begin
		fd_s1_idx <= tjss_pkg::IDX_W'(feed_cnt_q);
		fd_s1_lik <= lik_q[feed_cnt_q];
	end

	// Total of all weights, summed as they enter the chain.
	always_ff @(posedge clk) begin
		if (in_acc && is_sample) begin
			total_q <= '0;
		end else if (wt_s2.vld) begin
			total_q <= total_q + wt_s2.weight;
		end
	end

	// Threshold ceil(u * total / 2^32) with one multiplier, low half of total first, then high half.
	always_ff @(posedge clk) begin
		if (state_q == tjss_pkg::ST_THRESH) begin
			case (thr_cnt_q)
				2'd0: begin
					mul_q <= 64'(u_q) * 64'(total_q[31:0]);
				end
				2'd1: begin
					frac_q <= 33'(mul_q[63:32]) + 33'(mul_q[31:0] != 32'd0);
					mul_q  <= 64'(u_q) * 64'(total_q[63:32]);
				end
				default: begin
					thresh_q <= mul_q + WW'(frac_q);
				end
			endcase
		end
	end

	// Scan of the sorted chain head: first prefix sum reaching the threshold, or the last active state.
	assign cum_next = cum_q + cell_held[0].weight;
	assign scan_hit = (state_q == tjss_pkg::ST_SCAN)
		&& ((cum_next >= thresh_q) || (KW'(scan_cnt_q) == (k_active - KW'(1))));

	always_ff @(posedge clk) begin
		if (state_q == tjss_pkg::ST_THRESH) begin
			cum_q <= '0;
		end else if (state_q == tjss_pkg::ST_SCAN) begin
			cum_q <= cum_next;
			if (scan_hit) begin
				chosen_q <= cell_held[0].idx;
			end
		end
	end

	// Sort chain: cleared on a new sample, shifted toward the head while scanning.
	assign cell_ctrl.clear = in_acc && is_sample;
	assign cell_ctrl.shift = (state_q == tjss_pkg::ST_SCAN) && !scan_hit;

	for (genvar c = 0; c < MAX_STATES; c++) begin : g_cell
		tjss_pkg::sort_entry_t ins_c;
		tjss_pkg::sort_entry_t shift_c;

		if (c == 0) begin : g_head
			assign ins_c = wt_s2;
		end else begin : g_body
			assign ins_c = cell_pass[c-1];
		end

		if (c == MAX_STATES - 1) begin : g_tail
			assign shift_c = '0;
		end else begin : g_mid
			assign shift_c = cell_held[c+1];
		end

		tjss_sort_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.ins_in   (ins_c),
			.shift_in (shift_c),
			.held     (cell_held[c]),
			.pass     (cell_pass[c])
		);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == tjss_pkg::ST_DONE) && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == tjss_pkg::ST_DONE) && out_free) begin
			sampled_state <= chosen_q + {3'b000, ~zero_based_q};
			sampled_node  <= node_q;
		end
	end

	// A new result only appears after the finish step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == tjss_pkg::ST_DONE))
	else $error("result raised outside the finish step");

	// The chain head holds a valid entry throughout the scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tjss_pkg::ST_SCAN) |-> cell_held[0].vld)
	else $error("scan reached an empty chain head");

	// A finished sample with no result waiting is presented in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tjss_pkg::ST_DONE) && !out_valid) |=> out_valid)
	else $error("finished sample not presented");

endmodule
